// ===== hdl/frd_pkg.sv =====
// Shared types and constants for the fraction to repeating decimal block.
package frd_pkg;

  localparam int NUM_W     = 32;
  localparam int DEN_W     = 8;
  localparam int DIGIT_W   = 4;
  localparam int IDX_W     = 6;
  localparam int INT_W     = 32;
  localparam logic [IDX_W-1:0] LAST_IDX = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ERR,
    ST_REM,
    ST_DIG,
    ST_LOOK,
    ST_EMIT
  } frd_state_t;

  typedef enum logic [1:0] {
    KIND_ERR,
    KIND_INT,
    KIND_DIGIT
  } frd_kind_t;

  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      seed;
    logic      dig_init;
    logic      dig_step;
    logic      commit;
    logic      out_load;
    frd_kind_t kind;
  } frd_cmd_t;

  typedef struct packed {
    logic bad_den;
    logic div_last;
    logic rem_zero;
    logic dig_last;
    logic dig_final;
    logic out_free;
  } frd_sts_t;

endpackage

// ===== hdl/frd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module frd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/frd_datapath.sv =====
// Datapath: operand capture, restoring divider, digit unit, remainder table and result register.
module frd_datapath #(
  parameter int DEN_LIMIT = 64,
  parameter int NUM_BITS  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  frd_pkg::frd_cmd_t                    cmd,
  output frd_pkg::frd_sts_t                    sts,
  input  logic signed [frd_pkg::NUM_W-1:0]     in_numerator,
  input  logic signed [frd_pkg::DEN_W-1:0]     in_denominator,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_negative,
  output logic [frd_pkg::INT_W-1:0]            out_integer_part,
  output logic [frd_pkg::DIGIT_W-1:0]          out_digit,
  output logic                                 out_digit_valid,
  output logic [frd_pkg::IDX_W-1:0]            out_digit_index,
  output logic                                 out_has_repeat,
  output logic [frd_pkg::IDX_W-1:0]            out_repeat_start,
  output logic                                 out_divide_by_zero,
  output logic                                 out_last
);

  localparam int RW   = $clog2(DEN_LIMIT);
  localparam int DW   = RW + 1;
  localparam int PW   = RW + 4;
  localparam int CW   = (NUM_BITS < frd_pkg::NUM_W) ? NUM_BITS : frd_pkg::NUM_W;
  localparam int IW   = (NUM_BITS < frd_pkg::INT_W) ? NUM_BITS : frd_pkg::INT_W;
  localparam int CNTW = $clog2(NUM_BITS);

  logic [NUM_BITS-1:0]          nraw;
  logic [NUM_BITS-1:0]          nmag;
  logic                         nsign;
  logic [frd_pkg::DEN_W-1:0]    den_u;
  logic [frd_pkg::DEN_W-1:0]    dmag8;
  logic                         dsign;

  logic [NUM_BITS-1:0]          q_r;
  logic [DW-1:0]                dmag_r;
  logic                         neg_r;
  logic                         bad_r;
  logic [RW-1:0]                rem_r;
  logic [CNTW-1:0]              cnt_r;
  logic [PW-1:0]                prod_r;
  logic [frd_pkg::DIGIT_W-1:0]  digit_r;
  logic [1:0]                   dstep_r;
  logic [frd_pkg::IDX_W-1:0]    idx_r;
  logic [DEN_LIMIT-1:0]         seen_r;

  logic [DW-1:0]                div_t;
  logic                         div_ge;
  logic [RW-1:0]                div_rem;
  logic [PW-1:0]                dig_sub;
  logic                         dig_ge;
  logic [PW-1:0]                dig_prod;
  logic [PW-1:0]                prod_init;
  logic                         hit;
  logic                         rem_zero;
  logic                         cap;

  logic                         ram_we;
  logic [frd_pkg::IDX_W-1:0]    ram_wdata;
  logic [frd_pkg::IDX_W-1:0]    ram_rdata;

  logic                         out_valid_r;
  logic                         out_negative_r;
  logic [frd_pkg::INT_W-1:0]    out_integer_part_r;
  logic [frd_pkg::DIGIT_W-1:0]  out_digit_r;
  logic                         out_digit_valid_r;
  logic [frd_pkg::IDX_W-1:0]    out_digit_index_r;
  logic                         out_has_repeat_r;
  logic [frd_pkg::IDX_W-1:0]    out_repeat_start_r;
  logic                         out_divide_by_zero_r;
  logic                         out_last_r;

  assign den_u = in_denominator;

  always_comb begin
    nraw      = NUM_BITS'(in_numerator[CW-1:0]);
    nsign     = nraw[NUM_BITS-1];
    nmag      = nsign ? (~nraw + 1'b1) : nraw;
    dsign     = den_u[frd_pkg::DEN_W-1];
    dmag8     = dsign ? (~den_u + 1'b1) : den_u;

    div_t     = {rem_r, q_r[NUM_BITS-1]};
    div_ge    = (div_t >= dmag_r);
    div_rem   = div_ge ? RW'(div_t - dmag_r) : RW'(div_t);

    dig_sub   = PW'(dmag_r) << dstep_r;
    dig_ge    = (prod_r >= dig_sub);
    dig_prod  = dig_ge ? (prod_r - dig_sub) : prod_r;
    prod_init = (PW'(rem_r) << 3) + (PW'(rem_r) << 1);

    hit       = seen_r[rem_r];
    rem_zero  = (rem_r == '0);
    cap       = (idx_r == frd_pkg::LAST_IDX);

    ram_we    = cmd.seed || cmd.commit;
    ram_wdata = cmd.seed ? '0 : (idx_r + 1'b1);
  end

  always_comb begin
    sts.bad_den   = bad_r;
    sts.div_last  = (cnt_r == '0);
    sts.rem_zero  = rem_zero;
    sts.dig_last  = (dstep_r == 2'd0);
    sts.dig_final = rem_zero || hit || cap;
    sts.out_free  = !out_valid_r || out_ready;
  end

  frd_ram #(
    .WIDTH (frd_pkg::IDX_W),
    .DEPTH (DEN_LIMIT)
  ) u_seen_pos (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rem_r),
    .wdata (ram_wdata),
    .raddr (rem_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        seen_r <= '0;
      end else if (cmd.seed || cmd.commit) begin
        seen_r[rem_r] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r    <= nmag;
      dmag_r <= DW'(dmag8);
      bad_r  <= (dmag8 == '0) || (dmag8 > frd_pkg::DEN_W'(DEN_LIMIT));
      neg_r  <= (nmag != '0) && (nsign != dsign);
      rem_r  <= '0;
      cnt_r  <= CNTW'(NUM_BITS - 1);
      idx_r  <= '0;
    end
    if (cmd.div_step) begin
      q_r   <= {q_r[NUM_BITS-2:0], div_ge};
      rem_r <= div_rem;
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.dig_init) begin
      prod_r  <= prod_init;
      dstep_r <= 2'd3;
    end
    if (cmd.dig_step) begin
      prod_r  <= dig_prod;
      digit_r <= {digit_r[frd_pkg::DIGIT_W-2:0], dig_ge};
      dstep_r <= dstep_r - 1'b1;
      if (dstep_r == 2'd0) begin
        rem_r <= RW'(dig_prod);
      end
    end
    if (cmd.commit) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_negative_r       <= 1'b0;
      out_integer_part_r   <= '0;
      out_digit_r          <= '0;
      out_digit_valid_r    <= 1'b0;
      out_digit_index_r    <= '0;
      out_has_repeat_r     <= 1'b0;
      out_repeat_start_r   <= '0;
      out_divide_by_zero_r <= 1'b0;
      out_last_r           <= 1'b1;
      case (cmd.kind)
        frd_pkg::KIND_ERR: begin
          out_divide_by_zero_r <= 1'b1;
        end
        frd_pkg::KIND_INT: begin
          out_negative_r     <= neg_r;
          out_integer_part_r <= frd_pkg::INT_W'(q_r[IW-1:0]);
        end
        frd_pkg::KIND_DIGIT: begin
          out_negative_r     <= neg_r;
          out_integer_part_r <= frd_pkg::INT_W'(q_r[IW-1:0]);
          out_digit_r        <= digit_r;
          out_digit_valid_r  <= 1'b1;
          out_digit_index_r  <= idx_r;
          out_has_repeat_r   <= hit && !rem_zero;
          out_repeat_start_r <= (hit && !rem_zero) ? ram_rdata : '0;
          out_last_r         <= rem_zero || hit || cap;
        end
        default: begin
          out_divide_by_zero_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_negative       = out_negative_r;
  assign out_integer_part   = out_integer_part_r;
  assign out_digit          = out_digit_r;
  assign out_digit_valid    = out_digit_valid_r;
  assign out_digit_index    = out_digit_index_r;
  assign out_has_repeat     = out_has_repeat_r;
  assign out_repeat_start   = out_repeat_start_r;
  assign out_divide_by_zero = out_divide_by_zero_r;
  assign out_last           = out_last_r;

endmodule

// ===== hdl/frd_ctrl.sv =====
// Controller state machine sequencing the division, the digit loop and result beats.
module frd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  frd_pkg::frd_sts_t sts,
  output frd_pkg::frd_cmd_t cmd
);

  frd_pkg::frd_state_t state_r;
  frd_pkg::frd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.kind  = frd_pkg::KIND_DIGIT;
    unique case (state_r)
      frd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = frd_pkg::ST_DIVIDE;
        end
      end
      frd_pkg::ST_DIVIDE: begin
        if (sts.bad_den) begin
          state_nxt = frd_pkg::ST_ERR;
        end else begin
          cmd.div_step = 1'b1;
          if (sts.div_last) begin
            state_nxt = frd_pkg::ST_REM;
          end
        end
      end
      frd_pkg::ST_ERR: begin
        cmd.kind = frd_pkg::KIND_ERR;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = frd_pkg::ST_IDLE;
        end
      end
      frd_pkg::ST_REM: begin
        cmd.kind = frd_pkg::KIND_INT;
        if (sts.rem_zero) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = frd_pkg::ST_IDLE;
          end
        end else begin
          cmd.seed     = 1'b1;
          cmd.dig_init = 1'b1;
          state_nxt    = frd_pkg::ST_DIG;
        end
      end
      frd_pkg::ST_DIG: begin
        cmd.dig_step = 1'b1;
        if (sts.dig_last) begin
          state_nxt = frd_pkg::ST_LOOK;
        end
      end
      frd_pkg::ST_LOOK: begin
        state_nxt = frd_pkg::ST_EMIT;
      end
      frd_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.dig_final) begin
            state_nxt = frd_pkg::ST_IDLE;
          end else begin
            cmd.commit   = 1'b1;
            cmd.dig_init = 1'b1;
            state_nxt    = frd_pkg::ST_DIG;
          end
        end
      end
      default: begin
        state_nxt = frd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/fraction_to_repeating_decimal.sv =====
// Top level of the fraction to repeating decimal block; one fraction is worked at a time.
// The integer part comes from a one-bit-per-cycle restoring divider over NUM_BITS quotient bits.
// Digit beats follow the divider, each after its steps
// (4 compare-subtract steps, one table read, one beat slot; up to 64 digits); an exact quotient
// gives one integer beat, a refused denominator one error beat, and a stalled beat holds the controller.
// Synchronous active-low reset clears the controller, the output valid and the seen bits.
module fraction_to_repeating_decimal #(
  parameter int DEN_LIMIT = 64,
  parameter int NUM_BITS  = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [frd_pkg::NUM_W-1:0] in_numerator,
  input  logic signed [frd_pkg::DEN_W-1:0] in_denominator,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_negative,
  output logic [frd_pkg::INT_W-1:0]        out_integer_part,
  output logic [frd_pkg::DIGIT_W-1:0]      out_digit,
  output logic                             out_digit_valid,
  output logic [frd_pkg::IDX_W-1:0]        out_digit_index,
  output logic                             out_has_repeat,
  output logic [frd_pkg::IDX_W-1:0]        out_repeat_start,
  output logic                             out_divide_by_zero,
  output logic                             out_last
);

  frd_pkg::frd_cmd_t cmd;
  frd_pkg::frd_sts_t sts;

  frd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  frd_datapath #(
    .DEN_LIMIT (DEN_LIMIT),
    .NUM_BITS  (NUM_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_numerator       (in_numerator),
    .in_denominator     (in_denominator),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_negative       (out_negative),
    .out_integer_part   (out_integer_part),
    .out_digit          (out_digit),
    .out_digit_valid    (out_digit_valid),
    .out_digit_index    (out_digit_index),
    .out_has_repeat     (out_has_repeat),
    .out_repeat_start   (out_repeat_start),
    .out_divide_by_zero (out_divide_by_zero),
    .out_last           (out_last)
  );

endmodule

// ===== hdl/frd_checker.sv =====
// Port-level checker for the fraction to repeating decimal block, with its bind.
module frd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_negative,
  input logic [frd_pkg::INT_W-1:0]        out_integer_part,
  input logic [frd_pkg::DIGIT_W-1:0]      out_digit,
  input logic                             out_digit_valid,
  input logic [frd_pkg::IDX_W-1:0]        out_digit_index,
  input logic                             out_has_repeat,
  input logic [frd_pkg::IDX_W-1:0]        out_repeat_start,
  input logic                             out_divide_by_zero,
  input logic                             out_last
);

  // A stalled result beat stays valid and holds its digit, index, integer part and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit) && $stable(out_last)
      && $stable(out_digit_index) && $stable(out_integer_part))
    else $error("result beat changed while stalled");

  a_dz_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_last && !out_digit_valid && !out_negative
      && out_integer_part == '0)
    else $error("error beat carries a quotient");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_digit_valid |-> out_digit <= 4'd9)
    else $error("fractional digit out of range");

  a_repeat_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_repeat |-> out_last && out_digit_valid
      && out_repeat_start <= out_digit_index)
    else $error("repeat reported on a wrong beat");

  a_exact_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_digit_valid |-> out_last)
    else $error("beat without a digit is not the last");

endmodule

bind fraction_to_repeating_decimal frd_checker u_frd_checker (.*);
